// ===== hw/rtl/elevator_group_dispatcher_defines.svh =====
// Assertion macros shared by the elevator group dispatcher RTL.
// Each macro expects clk_i and rst_ni in the scope where it is used.
`ifndef ELEVATOR_GROUP_DISPATCHER_DEFINES_SVH
`define ELEVATOR_GROUP_DISPATCHER_DEFINES_SVH

// A condition that must hold at every clock edge out of reset.
`define EGD_ASSERT_ALWAYS(label, cond, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (cond)) else $error(msg);

// A condition that must hold in the same cycle as a trigger.
`define EGD_ASSERT_SAME(label, trig, cond, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (trig) |-> (cond)) \
    else $error(msg);

// A condition that must hold in the cycle after a trigger.
`define EGD_ASSERT_NEXT(label, trig, cond, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (trig) |=> (cond)) \
    else $error(msg);

`endif

// ===== hw/rtl/egd_pkg.sv =====
// Types and constants of the elevator group dispatcher.
// No dependencies; used by elevator_group_dispatcher.
package egd_pkg;

  typedef enum logic [1:0] {
    OP_TICK   = 2'd0,
    OP_HALL   = 2'd1,
    OP_CAR    = 2'd2,
    OP_RECALL = 2'd3
  } opcode_e;

  typedef enum logic [2:0] {
    ST_DONE     = 3'd0,
    ST_NO_FREE  = 3'd1,
    ST_OBSTACLE = 3'd2,
    ST_OVERLOAD = 3'd3,
    ST_IGNORED  = 3'd4
  } status_e;

  typedef enum logic [1:0] {
    HEAD_STOP = 2'd0,
    HEAD_UP   = 2'd1,
    HEAD_DOWN = 2'd2
  } heading_e;

  localparam int unsigned FloorW = 4;
  localparam int unsigned InDataW = 16;
  localparam int unsigned OutDataW = 24;
  // Floors and cars shown on the result lamps and arrival mask.
  localparam int unsigned LampW = 8;
  localparam int unsigned ArrivedW = 3;

endpackage

// ===== hw/rtl/elevator_group_dispatcher.sv =====
// Elevator group dispatcher: one request in, one result out, both as streams.
// The slave channel carries events (tick, hall call, car call, recall); each
// accepted request updates the car and lamp state and produces exactly one
// result on the master channel.
// The result is registered on the clock edge that accepts the request.
// Throughput is one request per cycle while the receiver does not stall, set
// by the single pass of state update logic between the state registers and the
// result register; every car is evaluated in parallel in that pass.
// s_axis_tready_o is high whenever the result register is empty or is being
// emptied in the same cycle, so a request may be taken while the previous
// result is handed over. When the receiver stalls, the result is held and no
// further request is taken until it leaves.
// After reset every car stands at floor one, stopped and without a target,
// all hall lamps are dark and the result register is empty.
// Depends on egd_pkg and elevator_group_dispatcher_defines.svh.
`include "elevator_group_dispatcher_defines.svh"

module elevator_group_dispatcher #(
  parameter int unsigned NUM_CARS   = 3,
  parameter int unsigned NUM_FLOORS = 8
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         s_axis_tvalid_i,
  output logic                         s_axis_tready_o,
  // opcode[1:0], car_index[3:2], floor[7:4], hall_up[8], obstacle_seen[9],
  // overload_seen[10], zero[15:11]
  input  logic [egd_pkg::InDataW-1:0]  s_axis_tdata_i,
  output logic                         m_axis_tvalid_o,
  input  logic                         m_axis_tready_i,
  // status[2:0], assigned_car[4:3], arrived_mask[7:5], up_lamps[15:8],
  // down_lamps[23:16]
  output logic [egd_pkg::OutDataW-1:0] m_axis_tdata_o
);

  localparam int unsigned PosW = $clog2(NUM_FLOORS + 1);
  localparam int unsigned CmpW = (PosW > egd_pkg::FloorW) ? PosW : egd_pkg::FloorW;
  localparam int unsigned CarW = (NUM_CARS > 1) ? $clog2(NUM_CARS) : 1;
  localparam int unsigned LampExtW =
    (NUM_FLOORS > egd_pkg::LampW) ? NUM_FLOORS : egd_pkg::LampW;
  localparam int unsigned ArrExtW =
    (NUM_CARS > egd_pkg::ArrivedW) ? NUM_CARS : egd_pkg::ArrivedW;

  // Request fields
  egd_pkg::opcode_e            op;
  logic [1:0]                  car_idx;
  logic [egd_pkg::FloorW-1:0]  fl;
  logic                        hall_up;
  logic                        obstacle;
  logic                        overload;
  logic                        s_fire;
  logic                        floor_ok;

  // Car and lamp state
  logic [PosW-1:0]             pos_q [NUM_CARS];
  logic [PosW-1:0]             pos_d [NUM_CARS];
  egd_pkg::heading_e           head_q [NUM_CARS];
  egd_pkg::heading_e           head_d [NUM_CARS];
  logic [NUM_CARS-1:0]         has_q, has_d;
  logic [egd_pkg::FloorW-1:0]  tgt_q [NUM_CARS];
  logic [egd_pkg::FloorW-1:0]  tgt_d [NUM_CARS];
  logic [NUM_FLOORS-1:0]       up_q, up_d, dn_q, dn_d;

  // Dispatch intermediates
  logic [CmpW-1:0]             car_span [NUM_CARS];
  logic [NUM_CARS-1:0]         free_car;
  logic [NUM_CARS-1:0]         car_sel;
  logic                        best_found;
  logic [CmpW-1:0]             best_dist;
  logic [CarW-1:0]             best_idx;
  logic [NUM_CARS-1:0]         best_oh;
  logic [NUM_CARS-1:0]         aim;
  logic                        do_move;
  egd_pkg::status_e            status;
  logic [1:0]                  assigned;
  logic [NUM_CARS-1:0]         arrived_all;
  logic [ArrExtW-1:0]          arrived_ext;
  logic [LampExtW-1:0]         up_ext, dn_ext;

  // Result register
  logic                        m_valid_q, m_valid_d;
  logic [egd_pkg::OutDataW-1:0] m_data_q;

  // Checks
  logic                        pos_in_range;
  logic                        stray_heading;

  assign op       = egd_pkg::opcode_e'(s_axis_tdata_i[1:0]);
  assign car_idx  = s_axis_tdata_i[3:2];
  assign fl       = s_axis_tdata_i[7:4];
  assign hall_up  = s_axis_tdata_i[8];
  assign obstacle = s_axis_tdata_i[9];
  assign overload = s_axis_tdata_i[10];

  assign s_axis_tready_o = !m_valid_q || m_axis_tready_i;
  assign s_fire          = s_axis_tvalid_i && s_axis_tready_o;
  assign floor_ok        = (fl != '0) && (CmpW'(fl) <= CmpW'(NUM_FLOORS));

  // Distance from every car to the requested floor, and the free cars.
  always_comb begin
    for (int c = 0; c < NUM_CARS; c++) begin
      if (CmpW'(pos_q[c]) > CmpW'(fl)) begin
        car_span[c] = CmpW'(pos_q[c]) - CmpW'(fl);
      end else begin
        car_span[c] = CmpW'(fl) - CmpW'(pos_q[c]);
      end
      free_car[c] = (head_q[c] == egd_pkg::HEAD_STOP) && !has_q[c];
      car_sel[c]  = (int'(car_idx) == c);
    end
  end

  // Nearest free car; a strict compare keeps the lowest index on a tie.
  always_comb begin
    best_found = 1'b0;
    best_dist  = '0;
    best_idx   = '0;
    best_oh    = '0;
    for (int c = 0; c < NUM_CARS; c++) begin
      if (free_car[c] && (!best_found || car_span[c] < best_dist)) begin
        best_found  = 1'b1;
        best_dist   = car_span[c];
        best_idx    = CarW'(c);
        best_oh     = '0;
        best_oh[c]  = 1'b1;
      end
    end
  end

  // State update for one request.
  always_comb begin
    pos_d       = pos_q;
    head_d      = head_q;
    has_d       = has_q;
    tgt_d       = tgt_q;
    up_d        = up_q;
    dn_d        = dn_q;
    status      = egd_pkg::ST_DONE;
    assigned    = '0;
    arrived_all = '0;
    do_move     = 1'b0;
    aim         = '0;

    unique case (op)
      egd_pkg::OP_TICK: begin
        do_move = 1'b1;
      end
      egd_pkg::OP_HALL: begin
        if (!floor_ok) begin
          status = egd_pkg::ST_IGNORED;
        end else begin
          for (int f = 0; f < NUM_FLOORS; f++) begin
            if (fl == egd_pkg::FloorW'(f + 1)) begin
              if (hall_up) begin
                up_d[f] = 1'b1;
              end else begin
                dn_d[f] = 1'b1;
              end
            end
          end
          if (best_found) begin
            aim      = best_oh;
            assigned = 2'(best_idx);
            do_move  = 1'b1;
          end else begin
            status = egd_pkg::ST_NO_FREE;
          end
        end
      end
      egd_pkg::OP_CAR: begin
        if (!(|car_sel) || !floor_ok) begin
          status = egd_pkg::ST_IGNORED;
        end else if (obstacle || overload) begin
          for (int c = 0; c < NUM_CARS; c++) begin
            if (car_sel[c]) begin
              head_d[c] = egd_pkg::HEAD_STOP;
            end
          end
          status = obstacle ? egd_pkg::ST_OBSTACLE : egd_pkg::ST_OVERLOAD;
        end else if (|(has_q & car_sel)) begin
          status = egd_pkg::ST_IGNORED;
        end else begin
          aim     = car_sel;
          do_move = 1'b1;
        end
      end
      egd_pkg::OP_RECALL: begin
        for (int c = 0; c < NUM_CARS; c++) begin
          has_d[c]  = 1'b1;
          tgt_d[c]  = egd_pkg::FloorW'(1);
          head_d[c] = (pos_q[c] == PosW'(1)) ? egd_pkg::HEAD_STOP : egd_pkg::HEAD_DOWN;
        end
      end
      default: begin
        status = egd_pkg::ST_IGNORED;
      end
    endcase

    // A car aimed at its own floor keeps its heading and arrives on the move.
    for (int c = 0; c < NUM_CARS; c++) begin
      if (aim[c]) begin
        has_d[c] = 1'b1;
        tgt_d[c] = fl;
        if (CmpW'(pos_q[c]) > CmpW'(fl)) begin
          head_d[c] = egd_pkg::HEAD_DOWN;
        end else if (CmpW'(pos_q[c]) < CmpW'(fl)) begin
          head_d[c] = egd_pkg::HEAD_UP;
        end
      end
    end

    // Cars are handled in index order so that two arrivals at one floor
    // clear the up lamp first and the down lamp second.
    if (do_move) begin
      for (int c = 0; c < NUM_CARS; c++) begin
        if (has_d[c]) begin
          if (head_d[c] == egd_pkg::HEAD_UP && pos_d[c] < PosW'(NUM_FLOORS)) begin
            pos_d[c] = pos_d[c] + PosW'(1);
          end else if (head_d[c] == egd_pkg::HEAD_DOWN && pos_d[c] > PosW'(1)) begin
            pos_d[c] = pos_d[c] - PosW'(1);
          end
          if (CmpW'(pos_d[c]) == CmpW'(tgt_d[c])) begin
            head_d[c]      = egd_pkg::HEAD_STOP;
            has_d[c]       = 1'b0;
            arrived_all[c] = 1'b1;
            for (int f = 0; f < NUM_FLOORS; f++) begin
              if (tgt_d[c] == egd_pkg::FloorW'(f + 1)) begin
                if (up_d[f]) begin
                  up_d[f] = 1'b0;
                end else if (dn_d[f]) begin
                  dn_d[f] = 1'b0;
                end
              end
            end
          end
        end
      end
    end
  end

  assign arrived_ext = ArrExtW'(arrived_all);
  assign up_ext      = LampExtW'(up_d);
  assign dn_ext      = LampExtW'(dn_d);

  always_comb begin
    m_valid_d = m_valid_q;
    if (s_fire) begin
      m_valid_d = 1'b1;
    end else if (m_axis_tready_i) begin
      m_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      m_valid_q <= 1'b0;
      has_q     <= '0;
      up_q      <= '0;
      dn_q      <= '0;
      for (int c = 0; c < NUM_CARS; c++) begin
        pos_q[c]  <= PosW'(1);
        head_q[c] <= egd_pkg::HEAD_STOP;
      end
    end else begin
      m_valid_q <= m_valid_d;
      if (s_fire) begin
        has_q  <= has_d;
        up_q   <= up_d;
        dn_q   <= dn_d;
        pos_q  <= pos_d;
        head_q <= head_d;
      end
    end
  end

  // Targets are only read while the matching target flag is set.
  always_ff @(posedge clk_i) begin
    if (s_fire) begin
      tgt_q    <= tgt_d;
      m_data_q <= {dn_ext[egd_pkg::LampW-1:0], up_ext[egd_pkg::LampW-1:0],
                   arrived_ext[egd_pkg::ArrivedW-1:0], assigned, status};
    end
  end

  assign m_axis_tvalid_o = m_valid_q;
  assign m_axis_tdata_o  = m_data_q;

  always_comb begin
    pos_in_range  = 1'b1;
    stray_heading = 1'b0;
    for (int c = 0; c < NUM_CARS; c++) begin
      if (pos_q[c] == '0 || pos_q[c] > PosW'(NUM_FLOORS)) begin
        pos_in_range = 1'b0;
      end
      if (!has_q[c] && head_q[c] != egd_pkg::HEAD_STOP) begin
        stray_heading = 1'b1;
      end
    end
  end

  `EGD_ASSERT_ALWAYS(a_pos_in_range, pos_in_range, "car position left the served floors")
  `EGD_ASSERT_ALWAYS(a_idle_car_stopped, !stray_heading, "car without target is moving")
  `EGD_ASSERT_NEXT(a_recall_targets, s_fire && op == egd_pkg::OP_RECALL, &has_q,
    "recall left a car without target")
  `EGD_ASSERT_SAME(a_assigned_done, m_valid_q && m_data_q[4:3] != 2'd0,
    m_data_q[2:0] == egd_pkg::ST_DONE, "car assigned on a refused request")

endmodule
